FILE: hdl/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared property shorthands, reset-aware, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Capacity, codes, beat types and controller types shared by all modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY      = 8;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int DATA_W        = 32;
	localparam int ENTRY_COUNT_W = 4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     req_type;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] removed_value;
		logic signed [DATA_W-1:0] head_value;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

FILE: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Two-state sequencer: capture a request, then run one update cycle.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output spq_pkg::ctrl_cmd_t cmd
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	`SPQ_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy && !cmd.load, "accepted request did not start execution")
	`SPQ_ASSERT_NEXT(a_exec_one_cycle, clk, arst_n, cmd.exec, !cmd.exec, "execution lasted more than one cycle")

endmodule

FILE: hdl/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Request register, sorted entry row with parallel compare and shift,
// live count and registered result.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::ctrl_cmd_t cmd,
	input  spq_pkg::req_t      req,
	output logic               done,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	req_t                     req_q;
	logic signed [DATA_W-1:0] entries_q [CAPACITY];
	logic signed [DATA_W-1:0] entries_d [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     done_q;
	rsp_t                     rsp_q;
	rsp_t                     rsp_d;

	logic [CAPACITY-1:0]      at_or_after;
	logic                     ins_ok;
	logic                     rem_ok;

	// Store is kept sorted, so the compare vector is monotone over live slots:
	// a slot lies at or after the insert point when the value wins there or the
	// slot is past the live range.
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			at_or_after[k] = (CNT_W'(k) >= count_q) || (req_q.value >= entries_q[k]);
		end
	end

	assign ins_ok = (req_q.req_type == REQ_INSERT) && (count_q != CNT_W'(CAPACITY));
	assign rem_ok = (req_q.req_type == REQ_REMOVE) && (count_q != '0);

	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			entries_d[k] = entries_q[k];
		end
		count_d = count_q;
		if (ins_ok) begin
			entries_d[0] = at_or_after[0] ? req_q.value : entries_q[0];
			for (int k = 1; k < CAPACITY; k++) begin
				if (!at_or_after[k]) begin
					entries_d[k] = entries_q[k];
				end else if (!at_or_after[k-1]) begin
					entries_d[k] = req_q.value;
				end else begin
					entries_d[k] = entries_q[k-1];
				end
			end
			count_d = count_q + 1'b1;
		end else if (rem_ok) begin
			for (int k = 0; k < CAPACITY - 1; k++) begin
				entries_d[k] = entries_q[k+1];
			end
			count_d = count_q - 1'b1;
		end
	end

	always_comb begin
		rsp_d.status = STATUS_OK;
		if ((req_q.req_type == REQ_INSERT) && !ins_ok) rsp_d.status = STATUS_OVERFLOW;
		if ((req_q.req_type == REQ_REMOVE) && !rem_ok) rsp_d.status = STATUS_UNDERFLOW;
		rsp_d.removed_value = rem_ok ? entries_q[0] : '0;
		rsp_d.head_value    = (count_d != '0) ? entries_d[0] : '0;
		rsp_d.entry_count   = ENTRY_COUNT_W'(count_d);
		rsp_d.is_empty      = (count_d == '0);
		rsp_d.is_full       = (count_d == CNT_W'(CAPACITY));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.exec) begin
			rsp_q <= rsp_d;
			for (int k = 0; k < CAPACITY; k++) begin
				entries_q[k] <= entries_d[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) count_q <= count_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SPQ_ASSERT_IMPL(a_count_bounded, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY), "live count exceeds capacity")
	`SPQ_ASSERT_IMPL(a_overflow_only_full, clk, arst_n, done_q && (rsp_q.status == STATUS_OVERFLOW), rsp_q.is_full && (rsp_q.removed_value == '0), "overflow reported on a queue that is not full")
	`SPQ_ASSERT_NEXT(a_exec_strobes, clk, arst_n, cmd.exec, done_q && (rsp_q.entry_count == ENTRY_COUNT_W'(count_q)), "result beat does not match the live count")

	for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order
		`SPQ_ASSERT_IMPL(a_sorted, clk, arst_n, CNT_W'(g + 1) < count_q, entries_q[g] >= entries_q[g+1], "store lost descending order")
	end

endmodule

FILE: hdl/sorted_priority_queue.sv
// Flow: a request accepted with busy low is loaded into req_q as the controller
// enters ST_EXEC; that update registers the result beat and raises done_q.
// Pacing: no request is taken while busy; busy is high for the single update
// cycle in which all slots are compared against the value and shifted at once.
// Reset: arst_n clears the live count and the controller; entries are undefined
// until written. The receiver cannot stall, so each result beat lasts one cycle.
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Descending-order queue of signed 32-bit values: insert by priority, remove
// largest, one result beat per request.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  spq_pkg::req_t  req,
	output logic           done,
	output spq_pkg::rsp_t  rsp
);
	import spq_pkg::*;

	// Command bundle from the sequencer: load captures the request beat,
	// exec commits the compare-and-shift and registers the result.
	ctrl_cmd_t cmd;

	// Sequencer: idle until start, then one update cycle with busy held high.
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: sorted slot row, live count, result register. The result beat
	// comes up in the cycle after exec, which is also a cycle where a new
	// request may be accepted.
	spq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

FILE: verif/spq_result_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue result checker
// Watches the request and result channels, predicts each result beat from its
// own copy of the queue, and compares every field against the oldest pending
// expectation.
// ----------------------------------------------------------------------------
module spq_result_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  spq_pkg::req_t  req,
	input  logic           done,
	input  spq_pkg::rsp_t  rsp,
	output int             fail_count,
	output int             outstanding,
	output int             results_seen,
	output int             overflow_seen,
	output int             underflow_seen,
	output int             full_seen
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] queue_store [CAPACITY];
	int                       queue_len;
	rsp_t                     pending_results [$];

	// Apply one request to the shadow queue and return the beat it must produce.
	function automatic rsp_t next_queue_result(req_t r);
		rsp_t o;
		int   pos;
		int   k;
		o = '0;
		o.status = STATUS_OK;
		if (r.req_type == REQ_INSERT) begin
			if (queue_len >= CAPACITY) begin
				o.status = STATUS_OVERFLOW;
			end else begin
				// land ahead of the first entry that is not greater; ties go first
				pos = queue_len;
				for (k = 0; k < queue_len; k++) begin
					if ($signed(r.value) >= $signed(queue_store[k])) begin
						pos = k;
						break;
					end
				end
				for (k = queue_len; k > pos; k--)
					queue_store[k] = queue_store[k-1];
				queue_store[pos] = r.value;
				queue_len++;
			end
		end else begin
			if (queue_len == 0) begin
				o.status = STATUS_UNDERFLOW;
			end else begin
				o.removed_value = queue_store[0];
				for (k = 1; k < queue_len; k++)
					queue_store[k-1] = queue_store[k];
				queue_len--;
			end
		end
		o.head_value  = (queue_len > 0) ? queue_store[0] : '0;
		o.entry_count = ENTRY_COUNT_W'(queue_len);
		o.is_empty    = (queue_len == 0);
		o.is_full     = (queue_len == CAPACITY);
		return o;
	endfunction

	function automatic void compare_field(string field, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// Check the result beat first, then queue the prediction for a new request.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			queue_len = 0;
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (done === 1'b1) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result beat with no request waiting");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", 64'(want.status), 64'(rsp.status));
					compare_field("removed_value", 64'(want.removed_value),
						64'(rsp.removed_value));
					compare_field("head_value", 64'(want.head_value),
						64'(rsp.head_value));
					compare_field("entry_count", 64'(want.entry_count),
						64'(rsp.entry_count));
					compare_field("is_empty", 64'(want.is_empty), 64'(rsp.is_empty));
					compare_field("is_full", 64'(want.is_full), 64'(rsp.is_full));
					if (want.status == STATUS_OVERFLOW)
						overflow_seen++;
					if (want.status == STATUS_UNDERFLOW)
						underflow_seen++;
					if (want.is_full)
						full_seen++;
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				pending_results.push_back(next_queue_result(req));
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: verif/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove requests in random bursts: a directed pass over the
// value extremes, ties, tail appends, overflow and underflow, then random
// traffic that swings the queue between empty and full. A checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int results_seen;
	int overflow_seen;
	int underflow_seen;
	int full_seen;

	int requests_sent;
	int burst_left;
	int cycle_cnt;

	always #HALF_PERIOD clk = ~clk;

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	spq_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.done           (done),
		.rsp            (rsp),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.overflow_seen  (overflow_seen),
		.underflow_seen (underflow_seen),
		.full_seen      (full_seen)
	);

	// Present one request beat and hold it until an edge takes it with busy low.
	task automatic issue(input logic kind, input logic signed [DATA_W-1:0] v);
		req_t item;
		item.req_type = kind;
		item.value    = v;
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		requests_sent++;
	endtask

	// Advance the current burst; at its end drop start for a random gap and
	// scramble the request bus so the block must ignore it while start is low.
	task automatic pace();
		int   gap;
		req_t noise;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) begin
				noise.req_type = 1'($urandom_range(0, 1));
				noise.value    = $urandom;
				req <= noise;
				@(posedge clk);
			end
			// mostly short bursts, now and then a long back-to-back stretch
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	// Mix extremes and a narrow band around zero so ties show up often.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $signed($urandom_range(0, 6)) - 3;
			4:       return $signed($urandom_range(0, 15)) - 32'sh7FFF_FFF8;
			default: return $urandom;
		endcase
	endfunction

	// Watchdog: a hung handshake or a missing beat ends the run here.
	initial begin
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int seg_left;
		int insert_pct;
		int directed_sent;
		start      <= 1'b0;
		req        <= '0;
		arst_n     <= 1'b0;
		burst_left = 0;
		seg_left   = 0;
		insert_pct = 50;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass: underflow on an empty queue first.
		issue(REQ_REMOVE, 32'sh1234_5678);
		pace();
		// Fill with extremes, a tail append below everything, and ties.
		issue(REQ_INSERT, 32'sd0);
		pace();
		issue(REQ_INSERT, 32'sh7FFF_FFFF);
		pace();
		issue(REQ_INSERT, 32'sh8000_0000);
		pace();
		issue(REQ_INSERT, -32'sd1);
		pace();
		issue(REQ_INSERT, 32'sd5);
		pace();
		issue(REQ_INSERT, 32'sd5);
		pace();
		issue(REQ_INSERT, 32'sh7FFF_FFFF);
		pace();
		issue(REQ_INSERT, 32'sh8000_0000);
		pace();
		// Queue is full now: both of these must be dropped as overflow.
		issue(REQ_INSERT, 32'sh7FFF_FFFF);
		pace();
		issue(REQ_INSERT, 32'sh5555_5555);
		pace();
		// Drain in descending order, then underflow once more.
		repeat (CAPACITY) begin
			issue(REQ_REMOVE, $urandom);
			pace();
		end
		issue(REQ_REMOVE, 32'shAAAA_AAAA);
		pace();
		// Single entry at the lowest value, in and out again.
		issue(REQ_INSERT, 32'sh8000_0000);
		pace();
		issue(REQ_REMOVE, 32'sh0);
		pace();
		directed_sent = requests_sent;

		// Random pass: segments lean toward filling, draining or churning so
		// the queue keeps crossing every fill level, full and empty included.
		repeat (RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0:       insert_pct = 15;
					1:       insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			seg_left--;
			issue(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
				pick_value());
			pace();
		end
		start <= 1'b0;

		// Wait out the remaining beats, then let the pipe settle.
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Summary: %0d requests (%0d directed), %0d result beats checked",
			requests_sent, directed_sent, results_seen);
		$display("Reached: %0d overflow drops, %0d underflow removes, %0d full beats",
			overflow_seen, underflow_seen, full_seen);
		if (outstanding != 0)
			$error("%0d result beats never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
